[rtl/mpsc_pkg.sv]
// Package for the motor PI speed controller: opcodes, register indexes,
// reset values, stream widths and divider constants.
// No dependencies.
package mpsc_pkg;

  // Opcodes carried in s_axis_tuser
  typedef enum logic [1:0] {
    OP_SET_SPEED = 2'd0,
    OP_SET_DIR   = 2'd1,
    OP_STOP      = 2'd2,
    OP_UPDATE    = 2'd3
  } opcode_e;

  // Configuration register indexes
  localparam logic [1:0] REG_PROP_GAIN   = 2'd0;
  localparam logic [1:0] REG_INTEG_GAIN  = 2'd1;
  localparam logic [1:0] REG_START_POWER = 2'd2;
  localparam logic [1:0] REG_MIN_SPEED   = 2'd3;

  localparam logic [15:0] PROP_GAIN_RST   = 16'd1024;
  localparam logic [15:0] INTEG_GAIN_RST  = 16'd512;
  localparam logic [7:0]  START_POWER_RST = 8'd110;
  localparam logic [15:0] MIN_SPEED_RST   = 16'd256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 104;  // 97 field bits padded to bytes
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;   // 44 field bits padded to bytes

  localparam logic [31:0] KICK_SLOTS = 32'd4;
  localparam logic [7:0]  DUTY_MAX   = 8'd255;

  // Integral accumulator: 48-bit signed, duty units in Q.16
  localparam int ACC_W = 48;
  localparam int PWR_W = 50;

  // Constant divider: microseconds to seconds, radix 2^16 digits.
  // For a partial p < 2^36: p / 1e6 = ((p >> 6) * DIV_RECIP) >> 44,
  // since 1e6 = 64 * 15625 and DIV_RECIP = ceil(2^44 / 15625).
  localparam int          DIV_NUM_W       = 64;
  localparam int          DIV_QUO_W       = 45;
  localparam int          DIV_REM_W       = 20;
  localparam int          DIV_DIG_W       = 16;
  localparam int          DIV_CNT_W       = 3;   // 4 digits, 2 products each
  localparam int          DIV_PRE_SHIFT   = 6;
  localparam int          DIV_RECIP_SHIFT = 44;
  localparam logic [31:0] DIV_RECIP       = 32'd1125899907;
  localparam logic [DIV_REM_W-1:0] US_PER_SECOND = 20'd1000000;

endpackage

[rtl/mpsc_div.sv]
// Divider by the constant one million in radix 2^16: each quotient digit is
// estimated by a reciprocal product and its remainder found by a back product,
// both on the caller's shared multiplier. Depends on mpsc_pkg.
module mpsc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mpsc_pkg::DIV_NUM_W-1:0] dividend_i,
  output logic [31:0]                    mul_a_o,
  output logic [31:0]                    mul_b_o,
  input  logic [63:0]                    mul_p_i,
  output logic                           done_o,
  output logic [mpsc_pkg::DIV_QUO_W-1:0] quotient_o
);
  import mpsc_pkg::*;

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [DIV_CNT_W-1:0]           cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0]           num_q, num_d;
  logic [DIV_REM_W-1:0]           rem_q, rem_d;
  logic [DIV_DIG_W-1:0]           dig_q, dig_d;
  logic [DIV_QUO_W-1:0]           quo_q, quo_d;
  logic [DIV_REM_W+DIV_DIG_W-1:0] part;

  always_comb begin
    // running remainder with the next dividend digit appended
    part    = {rem_q, num_q[DIV_NUM_W-1 -: DIV_DIG_W]};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    num_d   = num_q;
    rem_d   = rem_q;
    dig_d   = dig_q;
    quo_d   = quo_q;
    mul_a_o = '0;
    mul_b_o = '0;
    if (busy_q) begin
      if (!cnt_q[0]) begin
        mul_a_o = 32'(part[DIV_REM_W+DIV_DIG_W-1:DIV_PRE_SHIFT]);
        mul_b_o = DIV_RECIP;
      end else begin
        mul_a_o = 32'(dig_q);
        mul_b_o = 32'(US_PER_SECOND);
      end
    end
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (!cnt_q[0]) begin
        dig_d = mul_p_i[DIV_RECIP_SHIFT +: DIV_DIG_W];
      end else begin
        // true remainder is below 2^20, so the low bits suffice
        rem_d = part[DIV_REM_W-1:0] - mul_p_i[DIV_REM_W-1:0];
        quo_d = {quo_q[DIV_QUO_W-DIV_DIG_W-1:0], dig_q};
        num_d = {num_q[DIV_NUM_W-DIV_DIG_W-1:0], {DIV_DIG_W{1'b0}}};
        if (cnt_q == {DIV_CNT_W{1'b1}}) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dig_q <= dig_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[rtl/motor_pi_speed_controller_unit.sv]
// Top level of the motor PI speed controller with kick-start: stream ports,
// configuration registers, sequencer and one shared multiplier.
// Depends on mpsc_pkg and mpsc_div.
//
// Channel   Direction  Handshake             Contents
// s_axis    in         tvalid/tready         tuser: opcode; tdata: command item
// m_axis    out        tvalid/tready         tdata: result item
// cfg       in         cfg_we_i, no wait     cfg_idx_i selects, cfg_data_i value
//
// Sequence: set speed, set direction, stop, zero-target update and kick-start
// update go from decode straight to output load. A PI update runs two passes
// through the shared 32x32 multiplier, the divider by one million (four 16-bit
// digits, each a reciprocal and a back product on the same multiplier, plus
// the done flag), integral step, proportional product, power sum and output
// load; output load waits while a result in the output register is untaken.
// The input is ready only when the sequencer is idle; a result waiting in the
// output register does not block acceptance of the next item.
// Reset is asynchronous and active low; all control state and the controller
// state clear at once, config registers take their defaults.
module motor_pi_speed_controller_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: target_speed[15:0], go_backward[16], measured_speed[32:17],
  //        slot_count[64:33], now_us[96:65], zero pad
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [mpsc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [mpsc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
  // tdata: duty[7:0], duty_written[8], pins_off[9], backward[10],
  //        kick_phase[11], saturated_us[43:12], zero pad
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [mpsc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic [mpsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mpsc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mpsc_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DECODE = 4'd1;
  localparam logic [3:0] ST_MUL1   = 4'd2;  // integ_gain * |e|
  localparam logic [3:0] ST_MUL2   = 4'd3;  // * dt, launch divider
  localparam logic [3:0] ST_DIV    = 4'd4;  // divider owns the multiplier
  localparam logic [3:0] ST_INTEG  = 4'd5;
  localparam logic [3:0] ST_PMUL   = 4'd6;  // prop_gain * |e|
  localparam logic [3:0] ST_POWER  = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;

  localparam logic signed [PWR_W-1:0] SAT_LEVEL = PWR_W'({DUTY_MAX, 16'd0});

  logic [3:0] state_q, state_d;

  // Configuration
  logic [15:0] prop_gain_q, integ_gain_q, min_speed_q;
  logic [7:0]  start_power_q;

  // Controller state
  logic [15:0]      target_q, target_d;
  logic [31:0]      kick_until_q, kick_until_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [31:0]      last_us_q, last_us_d;
  logic [31:0]      sat_q, sat_d;
  logic             dir_q, dir_d;

  // Latched item
  logic [1:0]  op_q;
  logic [15:0] tgt_q, meas_q;
  logic        back_q;
  logic [31:0] slots_q, now_q;

  // Working registers
  logic [15:0] mag_q, mag_d;
  logic        eneg_q, eneg_d;
  logic [31:0] dt_q, dt_d;
  logic [31:0] prod_q, prod_d;

  // Result fields
  logic [7:0] duty_q, duty_d;
  logic       wr_q, wr_d, off_q, off_d, kick_q, kick_d;

  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_out;

  // Divider
  logic                 div_start;
  logic                 div_done;
  logic [DIV_QUO_W-1:0] div_quo;
  logic [31:0]          div_mul_a, div_mul_b;

  // Arithmetic temporaries
  logic signed [ACC_W:0]   acc_sum;
  logic signed [32:0]      pe;
  logic signed [PWR_W-1:0] power;
  logic [32:0]             sat_sum;
  logic                    in_take;
  logic                    out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  always_comb begin
    unique case (state_q)
      ST_MUL1: begin
        mul_a = {16'd0, integ_gain_q};
        mul_b = {16'd0, mag_q};
      end
      ST_MUL2: begin
        mul_a = prod_q;
        mul_b = dt_q;
      end
      ST_DIV: begin
        mul_a = div_mul_a;
        mul_b = div_mul_b;
      end
      ST_PMUL: begin
        mul_a = {16'd0, prop_gain_q};
        mul_b = {16'd0, mag_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_out   = 64'(mul_a) * 64'(mul_b);
  assign div_start = (state_q == ST_MUL2);

  mpsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_out),
    .mul_a_o    (div_mul_a),
    .mul_b_o    (div_mul_b),
    .mul_p_i    (mul_out),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d      = state_q;
    target_d     = target_q;
    kick_until_d = kick_until_q;
    acc_d        = acc_q;
    last_us_d    = last_us_q;
    sat_d        = sat_q;
    dir_d        = dir_q;
    mag_d        = mag_q;
    eneg_d       = eneg_q;
    dt_d         = dt_q;
    prod_d       = prod_q;
    duty_d       = duty_q;
    wr_d         = wr_q;
    off_d        = off_q;
    kick_d       = kick_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;

    // integral step with 48-bit signed saturation
    if (eneg_q) begin
      acc_sum = {acc_q[ACC_W-1], acc_q} - (ACC_W+1)'(div_quo);
    end else begin
      acc_sum = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(div_quo);
    end

    pe      = eneg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
    power   = PWR_W'($signed(acc_q)) + PWR_W'(pe);
    sat_sum = {1'b0, sat_q} + {1'b0, dt_q};

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_take) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        duty_d  = '0;
        wr_d    = 1'b0;
        off_d   = 1'b0;
        kick_d  = 1'b0;
        state_d = ST_EMIT;
        unique case (opcode_e'(op_q))
          OP_SET_SPEED: begin
            if (tgt_q < min_speed_q) begin
              target_d = '0;
              off_d    = 1'b1;
            end else begin
              // restart from a stop: arm kick-start, preload integral
              if (target_q < min_speed_q) begin
                kick_until_d = slots_q + KICK_SLOTS;
                acc_d        = ACC_W'({start_power_q, 16'd0});
              end
              target_d = tgt_q;
            end
          end
          OP_SET_DIR: begin
            if (back_q != dir_q) begin
              target_d = '0;
              off_d    = 1'b1;
              dir_d    = back_q;
            end
          end
          OP_STOP: begin
            target_d = '0;
            off_d    = 1'b1;
          end
          OP_UPDATE: begin
            if (target_q != '0) begin
              wr_d = 1'b1;
              if (kick_until_q > slots_q) begin
                duty_d = start_power_q;
                kick_d = 1'b1;
              end else begin
                eneg_d    = (meas_q > target_q);
                mag_d     = (meas_q > target_q) ? (meas_q - target_q)
                                                : (target_q - meas_q);
                dt_d      = now_q - last_us_q;
                last_us_d = now_q;
                state_d   = ST_MUL1;
              end
            end
          end
        endcase
      end
      ST_MUL1: begin
        prod_d  = mul_out[31:0];
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_INTEG;
        end
      end
      ST_INTEG: begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
          acc_d = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          acc_d = acc_sum[ACC_W-1:0];
        end
        state_d = ST_PMUL;
      end
      ST_PMUL: begin
        prod_d  = mul_out[31:0];
        state_d = ST_POWER;
      end
      ST_POWER: begin
        if (power >= SAT_LEVEL) begin
          sat_d  = sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
          duty_d = DUTY_MAX;
        end else if (power < 0) begin
          duty_d = '0;
        end else begin
          duty_d = power[23:16];
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'd0, sat_q, kick_q, dir_q, off_q, wr_q, duty_q};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      prop_gain_q   <= PROP_GAIN_RST;
      integ_gain_q  <= INTEG_GAIN_RST;
      start_power_q <= START_POWER_RST;
      min_speed_q   <= MIN_SPEED_RST;
      target_q      <= '0;
      kick_until_q  <= '0;
      acc_q         <= '0;
      last_us_q     <= '0;
      sat_q         <= '0;
      dir_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      target_q     <= target_d;
      kick_until_q <= kick_until_d;
      acc_q        <= acc_d;
      last_us_q    <= last_us_d;
      sat_q        <= sat_d;
      dir_q        <= dir_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PROP_GAIN:   prop_gain_q   <= cfg_data_i;
          REG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i;
          REG_START_POWER: start_power_q <= cfg_data_i[7:0];
          REG_MIN_SPEED:   min_speed_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q    <= s_axis_tuser;
      tgt_q   <= s_axis_tdata[15:0];
      back_q  <= s_axis_tdata[16];
      meas_q  <= s_axis_tdata[32:17];
      slots_q <= s_axis_tdata[64:33];
      now_q   <= s_axis_tdata[96:65];
    end
    mag_q      <= mag_d;
    eneg_q     <= eneg_d;
    dt_q       <= dt_d;
    prod_q     <= prod_d;
    duty_q     <= duty_d;
    wr_q       <= wr_d;
    off_q      <= off_d;
    kick_q     <= kick_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[tb/motor_pi_speed_controller_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for motor_pi_speed_controller_unit: directed and random
// command streams, every result compared with a behavioral PI regulator model.
// Depends on mpsc_pkg and the controller RTL.
module motor_pi_speed_controller_unit_test;
  import mpsc_pkg::*;

  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam int     DRAIN_CYCLES = 80;   // well past the PI update path
  localparam int     MAX_REPORTS  = 40;   // keep the log short on a broken build
  localparam longint INTEG_HI     = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint INTEG_LO     = -INTEG_HI - 1;
  localparam longint DUTY_FULL    = longint'(DUTY_MAX) << 16;

  // Result transaction, laid out exactly as m_axis_tdata[43:0]
  typedef struct packed {
    logic [31:0] sat_us;
    logic        kick;
    logic        back;
    logic        off;
    logic        written;
    logic [7:0]  duty;
  } drive_report_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: target_speed[15:0], go_backward[16], measured_speed[32:17],
  //        slot_count[64:33], now_us[96:65], zero pad
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  // tuser: opcode[1:0]
  logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: duty[7:0], duty_written[8], pins_off[9], backward[10],
  //        kick_phase[11], saturated_us[43:12], zero pad
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // Regulator model: configuration copy and controller state
  logic [15:0] prop_gain_q;
  logic [15:0] integ_gain_q;
  logic [7:0]  start_power_q;
  logic [15:0] min_speed_q;
  logic [15:0] speed_goal;
  logic [31:0] kick_end_slot;
  longint      integral_q16;    // duty units, Q.16, held to 48-bit signed range
  logic [31:0] last_tick_us;
  logic [31:0] sat_total_us;
  logic        reverse_dir;

  drive_report_t expected_drive[$];   // one entry per accepted command, oldest first
  int            failures = 0;
  bit            idle_en  = 1'b1;     // random gaps on both stream sides

  always #1 clk_i = ~clk_i;

  motor_pi_speed_controller_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Advance the model by one command and return the result it must produce.
  function automatic drive_report_t predict_drive(opcode_e op, logic [15:0] speed, logic back,
                                                  logic [15:0] meas, logic [31:0] slot,
                                                  logic [31:0] now_us);
    drive_report_t   r;
    longint          err;
    longint          inc;
    longint          power;
    longint unsigned mag;
    longint unsigned step;
    logic [31:0]     dt;
    r = '0;
    case (op)
      OP_SET_SPEED: begin
        if (speed < min_speed_q) begin
          speed_goal = '0;
          r.off      = 1'b1;
        end else begin
          // restart from below the floor arms the kick and preloads the integral
          if (speed_goal < min_speed_q) begin
            kick_end_slot = slot + KICK_SLOTS;
            integral_q16  = longint'(start_power_q) << 16;
          end
          speed_goal = speed;
        end
      end
      OP_SET_DIR: begin
        if (back != reverse_dir) begin
          speed_goal  = '0;
          r.off       = 1'b1;
          reverse_dir = back;
        end
      end
      OP_STOP: begin
        // kick window and integral survive a stop
        speed_goal = '0;
        r.off      = 1'b1;
      end
      OP_UPDATE: begin
        if (speed_goal != '0) begin
          r.written = 1'b1;
          if (kick_end_slot > slot) begin
            // plain unsigned compare: an arm near wrap may give no kick at all
            r.duty = start_power_q;
            r.kick = 1'b1;
          end else begin
            err          = longint'(speed_goal) - longint'(meas);
            mag          = (err < 0) ? -err : err;
            dt           = now_us - last_tick_us;
            last_tick_us = now_us;
            step = 64'(integ_gain_q) * mag * 64'(dt) / 64'(US_PER_SECOND);
            inc  = longint'(step);
            if (err < 0) begin
              integral_q16 = (integral_q16 < INTEG_LO + inc) ? INTEG_LO : integral_q16 - inc;
            end else begin
              integral_q16 = (integral_q16 > INTEG_HI - inc) ? INTEG_HI : integral_q16 + inc;
            end
            power = longint'(prop_gain_q) * err + integral_q16;
            if (power >= DUTY_FULL) begin
              sat_total_us = (sat_total_us > 32'hFFFF_FFFF - dt) ? 32'hFFFF_FFFF
                                                                 : sat_total_us + dt;
            end
            if (power < 0)              r.duty = '0;
            else if (power >= DUTY_FULL) r.duty = DUTY_MAX;
            else                        r.duty = power[23:16];
          end
        end
      end
    endcase
    r.back   = reverse_dir;
    r.sat_us = sat_total_us;
    return r;
  endfunction

  // Drive one command transaction; called and returns on a falling edge.
  task automatic send_command(opcode_e op, logic [15:0] speed, logic back, logic [15:0] meas,
                              logic [31:0] slot, logic [31:0] now_us);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, now_us, slot, meas, back, speed};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_drive.push_back(predict_drive(op, speed, back, meas, slot, now_us));
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every pending result has been seen.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Leaves the write enable high; load_registers lowers it once at the end.
  task automatic put_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
  endtask

  task automatic load_registers(logic [15:0] prop, logic [15:0] integ, logic [7:0] kick_duty,
                                logic [15:0] floor_speed);
    settle();
    put_register(REG_PROP_GAIN, prop);
    put_register(REG_INTEG_GAIN, integ);
    put_register(REG_START_POWER, {8'd0, kick_duty});
    put_register(REG_MIN_SPEED, floor_speed);
    cfg_we_i      <= 1'b0;
    prop_gain_q   = prop;
    integ_gain_q  = integ;
    start_power_q = kick_duty;
    min_speed_q   = floor_speed;
  endtask

  // Mostly modest values, sometimes the extremes or anything at all.
  function automatic logic [15:0] pick_value(logic [15:0] typical_hi);
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, typical_hi));
    endcase
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      if (failures < MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
      failures++;
    end
  endtask

  // Result checker: every output transaction against the oldest prediction.
  always @(posedge clk_i) begin
    drive_report_t got;
    drive_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(drive_report_t)-1:0];
      if (expected_drive.size() == 0) begin
        if (failures < MAX_REPORTS) begin
          $display("%0t: result with nothing expected, expected none, actual 0x%0h",
                   $time, got);
        end
        failures++;
      end else begin
        want = expected_drive.pop_front();
        check_field("duty", want.duty, got.duty);
        check_field("duty_written", want.written, got.written);
        check_field("pins_off", want.off, got.off);
        check_field("backward", want.back, got.back);
        check_field("kick_phase", want.kick, got.kick);
        check_field("saturated_us", want.sat_us, got.sat_us);
      end
    end
  end

  // Result side back-pressure: random stall bursts while idling is on.
  initial begin
    forever begin
      @(negedge clk_i);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Reset defaults: ignored update, same direction, floor edge, kick window,
  // first PI steps with both error signs, retarget while running, saturation.
  task automatic test_reset_defaults();
    send_command(OP_UPDATE, 16'hFFFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(OP_SET_DIR, 16'd0, 1'b0, 16'd0, 32'd0, 32'd0);
    send_command(OP_SET_SPEED, 16'd255, 1'b0, 16'd0, 32'd0, 32'd0);    // just below floor
    send_command(OP_STOP, 16'd0, 1'b0, 16'd0, 32'd0, 32'd0);
    send_command(OP_SET_SPEED, 16'd256, 1'b0, 16'd0, 32'd100, 32'd0);  // kick to slot 104
    send_command(OP_UPDATE, 16'd0, 1'b0, 16'd0, 32'd100, 32'd1000);
    send_command(OP_UPDATE, 16'd0, 1'b0, 16'd0, 32'd103, 32'd2000);
    send_command(OP_UPDATE, 16'd0, 1'b0, 16'd0, 32'd104, 32'd5000);    // first PI step
    send_command(OP_UPDATE, 16'd0, 1'b0, 16'hFFFF, 32'd105, 32'd6000);
    send_command(OP_SET_SPEED, 16'hFFFF, 1'b0, 16'd0, 32'd106, 32'd0); // no re-arm
    send_command(OP_UPDATE, 16'd0, 1'b0, 16'd0, 32'd107, 32'd9000);    // runs at full duty
  endtask

  task automatic test_direction_changes();
    send_command(OP_SET_DIR, 16'd0, 1'b1, 16'd0, 32'd108, 32'd0);      // reversal stops
    send_command(OP_SET_DIR, 16'd0, 1'b1, 16'd0, 32'd108, 32'd0);      // no change
    send_command(OP_UPDATE, 16'd0, 1'b1, 16'd0, 32'd109, 32'd9500);    // target is zero
    send_command(OP_SET_DIR, 16'd0, 1'b0, 16'd0, 32'd109, 32'd0);
  endtask

  // Arm two slots before wrap: the kick end wraps to 2 and the window is empty.
  task automatic test_kick_wrap();
    send_command(OP_SET_SPEED, 16'd1000, 1'b0, 16'd0, 32'hFFFF_FFFE, 32'd0);
    send_command(OP_UPDATE, 16'd0, 1'b0, 16'd900, 32'hFFFF_FFFF, 32'd10000);
    send_command(OP_STOP, 16'd0, 1'b0, 16'd0, 32'd0, 32'd0);
    send_command(OP_UPDATE, 16'd0, 1'b0, 16'd0, 32'd1, 32'd11000);
  endtask

  task automatic test_register_extremes();
    load_registers(16'hFFFF, 16'd0, 8'hFF, 16'hFFFF);
    send_command(OP_SET_SPEED, 16'hFFFE, 1'b0, 16'd0, 32'd10, 32'd0);  // below top floor
    send_command(OP_SET_SPEED, 16'hFFFF, 1'b0, 16'd0, 32'd10, 32'd0);
    send_command(OP_UPDATE, 16'd0, 1'b0, 16'd0, 32'd13, 32'd15000);    // kick at full duty
    send_command(OP_UPDATE, 16'd0, 1'b0, 16'hFFFF, 32'd14, 32'd20000); // zero error
    load_registers(16'd0, 16'hFFFF, 8'd0, 16'd0);
    send_command(OP_SET_SPEED, 16'd0, 1'b0, 16'd0, 32'd15, 32'd0);     // zero floor, zero target
    send_command(OP_UPDATE, 16'd0, 1'b0, 16'd0, 32'd16, 32'd25000);
    send_command(OP_SET_SPEED, 16'd500, 1'b0, 16'd0, 32'd20, 32'd0);   // no arm with zero floor
    send_command(OP_UPDATE, 16'd0, 1'b0, 16'd400, 32'd20, 32'd30000);
  endtask

  // Near-maximal gain, error and elapsed time drive the integral into both
  // 48-bit limits and the saturation timer into its ceiling.
  task automatic test_integral_limits();
    logic [31:0] slot;
    logic [31:0] tick;
    load_registers(16'($urandom_range(0, 2048)), 16'hFFFF, 8'($urandom), 16'd1);
    slot = $urandom_range(0, 32'h7FFF_FFFF);
    tick = $urandom;
    send_command(OP_STOP, 16'($urandom), 1'b0, 16'($urandom), slot, tick);
    send_command(OP_SET_SPEED, 16'hFFFF, 1'b0, 16'd0, slot, tick);
    slot += KICK_SLOTS;
    repeat (10) begin
      tick -= $urandom_range(1, 5000);     // elapsed time just under 2^32
      send_command(OP_UPDATE, 16'($urandom), 1'b0, 16'($urandom_range(0, 255)), slot, tick);
      slot++;
    end
    send_command(OP_SET_SPEED, 16'd1, 1'b0, 16'd0, slot, tick);
    repeat (18) begin
      tick -= $urandom_range(1, 5000);
      send_command(OP_UPDATE, 16'($urandom), 1'b0, 16'hFFFF - 16'($urandom_range(0, 255)),
                   slot, tick);
      slot++;
    end
  endtask

  // Random phases: mostly well-formed speed/update sequences with a moving
  // slot count and clock, some stops, reversals and fully random commands.
  // The last phase runs with reset values and no idling.
  task automatic test_random_drive();
    logic [31:0] slot;
    logic [31:0] tick;
    logic [15:0] speed;
    int          level;
    int unsigned pick;
    opcode_e     op;
    slot = $urandom;
    tick = $urandom;
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 0 || phase == 6) begin
        load_registers(PROP_GAIN_RST, INTEG_GAIN_RST, START_POWER_RST, MIN_SPEED_RST);
      end else begin
        load_registers(pick_value(16'd4096), pick_value(16'd8192), 8'(pick_value(16'd255)),
                       pick_value(16'd1024));
      end
      idle_en = (phase == 6) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 85; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          // noise; a set speed keeps the running slot so the kick stays sane
          op = opcode_e'($urandom_range(0, 3));
          send_command(op, 16'($urandom), 1'($urandom), 16'($urandom),
                       (op == OP_SET_SPEED) ? slot : $urandom, $urandom);
        end else if (pick < 20) begin
          if (min_speed_q != 0 && $urandom_range(0, 7) == 0) begin
            speed = 16'($urandom_range(0, min_speed_q - 1));
          end else begin
            level = int'(min_speed_q) + int'($urandom_range(0, 4096));
            speed = (level > 65535) ? 16'hFFFF : 16'(level);
          end
          send_command(OP_SET_SPEED, speed, 1'($urandom), 16'($urandom), slot, tick);
        end else if (pick < 26) begin
          send_command(OP_SET_DIR, 16'($urandom), 1'($urandom), 16'($urandom), slot, tick);
        end else if (pick < 31) begin
          send_command(OP_STOP, 16'($urandom), 1'($urandom), 16'($urandom), slot, tick);
        end else begin
          slot += $urandom_range(0, 2);
          case ($urandom_range(0, 9))
            0:       tick += $urandom;
            1:       tick += 0;
            default: tick += $urandom_range(1, 20000);
          endcase
          // measured speed mostly near the target, sometimes anywhere
          if ($urandom_range(0, 9) == 0) begin
            speed = 16'($urandom);
          end else begin
            level = int'(speed_goal) + int'($urandom_range(0, 2048)) - 1024;
            speed = (level < 0) ? 16'd0 : (level > 65535) ? 16'hFFFF : 16'(level);
          end
          send_command(OP_UPDATE, 16'($urandom), 1'($urandom), speed, slot, tick);
        end
      end
    end
  endtask

  initial begin
    // model matches the block right after reset
    prop_gain_q   = PROP_GAIN_RST;
    integ_gain_q  = INTEG_GAIN_RST;
    start_power_q = START_POWER_RST;
    min_speed_q   = MIN_SPEED_RST;
    speed_goal    = '0;
    kick_end_slot = '0;
    integral_q16  = 0;
    last_tick_us  = '0;
    sat_total_us  = '0;
    reverse_dir   = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_direction_changes();
    test_kick_wrap();
    test_register_extremes();
    test_integral_limits();
    test_random_drive();

    // all results in, then give the block time to show anything spurious
    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/mpsc_pkg.sv
rtl/mpsc_div.sv
rtl/motor_pi_speed_controller_unit.sv
tb/motor_pi_speed_controller_unit_test.sv
